>>> rtl/wbc_pkg.sv
// Package for the window binarize and centroid unit.
// Holds configuration register indexes, reset values and result codes.
// No dependencies.
package wbc_pkg;

    // Width of the configuration index and data on the register port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEFT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_EMIT_BINARY   = 3'd6;

    // Register values after reset.
    localparam logic [7:0]  RST_THRESHOLD     = 8'd180;
    localparam logic [9:0]  RST_WINDOW_LEFT   = 10'd0;
    localparam logic [9:0]  RST_WINDOW_TOP    = 10'd0;
    localparam logic [10:0] RST_WINDOW_WIDTH  = 11'd248;
    localparam logic [10:0] RST_WINDOW_HEIGHT = 11'd240;
    localparam logic [10:0] RST_FRAME_WIDTH   = 11'd320;
    localparam logic        RST_EMIT_BINARY   = 1'b1;

    // Result kinds.
    localparam logic KIND_BINARY  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Pixel words for white and black.
    localparam logic [15:0] PIXEL_WHITE = 16'hFFFF;
    localparam logic [15:0] PIXEL_BLACK = 16'h0000;

    // Field widths of the result word.
    localparam int COUNT_W = 21;
    localparam int CENT_W  = 19;
    localparam int SUM_W   = 32;

    // Largest centroid value; larger quotients saturate to it.
    localparam logic [CENT_W-1:0] CENT_MAX = 19'd262143;

    // Width of window geometry arithmetic: holds left plus width and frame sizes.
    localparam int GEO_W = 14;

    // Smallest window area that still yields a centroid.
    localparam logic [2*GEO_W-1:0] MIN_AREA = 28'd8;

endpackage

>>> rtl/window_binarize_centroid_unit.sv
// Top level of the window binarize and centroid unit.
// Depends on wbc_pkg for register indexes, reset values and result codes.
//
//  channel   direction  signals                               payload
//  -------   ---------  ------------------------------------  -----------------------------
//  input     in         i_in_valid / o_in_stall               i_pixel_word, i_frame_start
//  result    out        o_out_valid / i_out_stall             o_result_kind .. o_last
//  config    in         i_cfg_valid / o_cfg_ready             i_cfg_index, i_cfg_data
//
// A pixel word is accepted, and a new word can follow in the next cycle
// whenever the result register is empty or is being emptied in the same cycle.
// The word that closes the crop window starts the centroid division: one shared
// restoring divider works one quotient bit per cycle, first for x and then for y,
// and the input stays stalled until both divisions are done and the summary word
// is loaded, which can wait on a stalled result channel. Without a division
// (no white pixel or a tiny window) the input stalls until the summary is loaded.
// Reset is synchronous and active low; it restores the register defaults and
// clears the frame position, sums and count.
module window_binarize_centroid_unit
    import wbc_pkg::*;
#(
    parameter int MAX_FRAME_WIDTH  = 1024,
    parameter int MAX_FRAME_HEIGHT = 1024,
    parameter int FRACTION_BITS    = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [15:0]              i_pixel_word,
    input  logic                     i_frame_start,

    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_result_kind,
    output logic [15:0]              o_binary_pixel,
    output logic [COUNT_W-1:0]       o_white_count,
    output logic signed [CENT_W-1:0] o_centroid_x,
    output logic signed [CENT_W-1:0] o_centroid_y,
    output logic                     o_last,

    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);

    // Column and row counter widths follow from the frame size limits.
    localparam int COL_W = $clog2(MAX_FRAME_WIDTH);
    localparam int ROW_W = (MAX_FRAME_HEIGHT > 1) ? $clog2(MAX_FRAME_HEIGHT) : 1;
    // The dividend is the sum shifted up by the fraction bits.
    localparam int DVD_W = SUM_W + FRACTION_BITS;
    localparam int STEP_W = $clog2(DVD_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DVD_W - 1);
    localparam logic [GEO_W-1:0] MAX_FW_G = GEO_W'(MAX_FRAME_WIDTH);
    localparam logic [GEO_W-1:0] MAX_FH_G = GEO_W'(MAX_FRAME_HEIGHT);
    // The "no centroid" value is -1.0 in the chosen fixed-point format.
    localparam logic [CENT_W-1:0] CENT_NONE = (~{CENT_W{1'b0}}) << FRACTION_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SUM
    } t_state;

    // Configuration registers.
    logic [7:0]  r_threshold;
    logic [9:0]  r_win_left;
    logic [9:0]  r_win_top;
    logic [10:0] r_win_width;
    logic [10:0] r_win_height;
    logic [10:0] r_frame_width;
    logic        r_emit_binary;

    // Sequencer and frame state.
    t_state             r_state, n_state;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [SUM_W-1:0]   r_sum_x, n_sum_x;
    logic [SUM_W-1:0]   r_sum_y, n_sum_y;
    logic [COUNT_W-1:0] r_white, n_white;
    logic               r_done, n_done;
    logic               r_none, n_none;

    // Shared divider.
    logic [DVD_W-1:0]   r_dvd, n_dvd;
    logic [COUNT_W-1:0] r_rem, n_rem;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_div_y, n_div_y;
    logic [CENT_W-1:0]  r_cent_x, n_cent_x;
    logic [CENT_W-1:0]  r_cent_y, n_cent_y;

    // Result register.
    logic               r_out_valid, n_out_valid;
    logic               r_out_kind, n_out_kind;
    logic [15:0]        r_out_pixel, n_out_pixel;
    logic [COUNT_W-1:0] r_out_count, n_out_count;
    logic [CENT_W-1:0]  r_out_cx, n_out_cx;
    logic [CENT_W-1:0]  r_out_cy, n_out_cy;
    logic               r_out_last, n_out_last;

    logic in_accept;
    logic slot_free;

    // Window geometry, taken from the live configuration.
    logic [GEO_W-1:0]   fw_g, left_g, top_g, right_raw, bottom_raw, right_g, bottom_g;
    logic [GEO_W-1:0]   span_w, span_h;
    logic [2*GEO_W-1:0] area;
    logic               empty_win, small_win;

    // Per-word decisions, after a frame start has cleared the frame state.
    logic [COL_W-1:0]   cur_col;
    logic [ROW_W-1:0]   cur_row;
    logic [SUM_W-1:0]   cur_sum_x, cur_sum_y;
    logic [COUNT_W-1:0] cur_white;
    logic               cur_done;
    logic [GEO_W-1:0]   col_g, row_g, col_inc, row_inc, dx, dy;
    logic               in_window, is_white, is_end, take_pixel, send_binary, send_summary;
    logic [SUM_W-1:0]   upd_sum_x;
    logic [COUNT_W-1:0] upd_white;

    // One divider step.
    logic [COUNT_W:0]   rem_shift;
    logic               rem_ge;
    logic [DVD_W-1:0]   quotient;
    logic [CENT_W-1:0]  quot_sat;

    // ------------------------------------------------------------------
    // Configuration port. Writes arrive only while the unit is idle.
    // ------------------------------------------------------------------
    assign o_cfg_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= RST_THRESHOLD;
            r_win_left    <= RST_WINDOW_LEFT;
            r_win_top     <= RST_WINDOW_TOP;
            r_win_width   <= RST_WINDOW_WIDTH;
            r_win_height  <= RST_WINDOW_HEIGHT;
            r_frame_width <= RST_FRAME_WIDTH;
            r_emit_binary <= RST_EMIT_BINARY;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_THRESHOLD:     r_threshold   <= i_cfg_data[7:0];
                CFG_WINDOW_LEFT:   r_win_left    <= i_cfg_data[9:0];
                CFG_WINDOW_TOP:    r_win_top     <= i_cfg_data[9:0];
                CFG_WINDOW_WIDTH:  r_win_width   <= i_cfg_data;
                CFG_WINDOW_HEIGHT: r_win_height  <= i_cfg_data;
                CFG_FRAME_WIDTH:   r_frame_width <= i_cfg_data;
                CFG_EMIT_BINARY:   r_emit_binary <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshakes. The result register is free when empty or being taken.
    // ------------------------------------------------------------------
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !slot_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    // ------------------------------------------------------------------
    // Window geometry. The right edge is clipped to the frame width and the
    // bottom edge to the frame height limit; the width is rounded down to a
    // multiple of eight. A zero or oversized frame width means the maximum.
    // ------------------------------------------------------------------
    always_comb begin
        fw_g = GEO_W'(r_frame_width);
        if (fw_g == '0 || fw_g > MAX_FW_G) begin
            fw_g = MAX_FW_G;
        end
        left_g     = GEO_W'(r_win_left);
        top_g      = GEO_W'(r_win_top);
        right_raw  = left_g + GEO_W'({r_win_width[10:3], 3'b000});
        bottom_raw = top_g + GEO_W'(r_win_height);
        right_g    = (right_raw > fw_g) ? fw_g : right_raw;
        bottom_g   = (bottom_raw > MAX_FH_G) ? MAX_FH_G : bottom_raw;
        empty_win  = (right_g <= left_g) || (bottom_g <= top_g);
        span_w     = empty_win ? '0 : right_g - left_g;
        span_h     = empty_win ? '0 : bottom_g - top_g;
        area       = span_w * span_h;
        small_win  = (area < MIN_AREA);
    end

    // ------------------------------------------------------------------
    // Pixel classification for the word on the input.
    // ------------------------------------------------------------------
    always_comb begin
        cur_col   = i_frame_start ? '0 : r_col;
        cur_row   = i_frame_start ? '0 : r_row;
        cur_sum_x = i_frame_start ? '0 : r_sum_x;
        cur_sum_y = i_frame_start ? '0 : r_sum_y;
        cur_white = i_frame_start ? '0 : r_white;
        cur_done  = i_frame_start ? 1'b0 : r_done;

        col_g = GEO_W'(cur_col);
        row_g = GEO_W'(cur_row);
        dx    = col_g - left_g;
        dy    = row_g - top_g;

        in_window = (col_g >= left_g) && (col_g < right_g) &&
                    (row_g >= top_g) && (row_g < bottom_g);
        is_white  = (i_pixel_word[7:0] >= r_threshold);
        is_end    = (col_g == right_g - GEO_W'(1)) && (row_g == bottom_g - GEO_W'(1));

        take_pixel   = !cur_done && !empty_win && in_window;
        send_binary  = take_pixel && r_emit_binary;
        send_summary = !cur_done && (empty_win || (in_window && is_end));

        upd_white = cur_white;
        upd_sum_x = cur_sum_x;
        n_sum_y   = cur_sum_y;
        if (take_pixel && is_white) begin
            upd_white = cur_white + COUNT_W'(1);
            upd_sum_x = cur_sum_x + SUM_W'(dx);
            n_sum_y   = cur_sum_y + SUM_W'(dy);
        end

        col_inc = col_g + GEO_W'(1);
        row_inc = row_g + GEO_W'(1);
    end

    // ------------------------------------------------------------------
    // Divider step: restoring division, one quotient bit per cycle. The
    // quotient bits shift into the dividend register from below.
    // ------------------------------------------------------------------
    always_comb begin
        rem_shift = {r_rem, r_dvd[DVD_W-1]};
        rem_ge    = (rem_shift >= {1'b0, r_white});
        quotient  = {r_dvd[DVD_W-2:0], rem_ge};
        quot_sat  = (|quotient[DVD_W-1:CENT_W-1]) ? CENT_MAX
                                                  : CENT_W'(quotient[CENT_W-2:0]);
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_sum_x     = r_sum_x;
        n_white     = r_white;
        n_done      = r_done;
        n_none      = r_none;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_step      = r_step;
        n_div_y     = r_div_y;
        n_cent_x    = r_cent_x;
        n_cent_y    = r_cent_y;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_kind  = r_out_kind;
        n_out_pixel = r_out_pixel;
        n_out_count = r_out_count;
        n_out_cx    = r_out_cx;
        n_out_cy    = r_out_cy;
        n_out_last  = r_out_last;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_white = upd_white;
                    n_sum_x = upd_sum_x;
                    n_done  = cur_done || send_summary;

                    // Advance the frame position; the row wraps at the height limit.
                    if (col_inc >= fw_g) begin
                        n_col = '0;
                        n_row = (row_inc >= MAX_FH_G) ? '0 : ROW_W'(row_inc);
                    end else begin
                        n_col = COL_W'(col_inc);
                        n_row = cur_row;
                    end

                    if (send_binary) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = KIND_BINARY;
                        n_out_pixel = is_white ? PIXEL_WHITE : PIXEL_BLACK;
                        n_out_count = '0;
                        n_out_cx    = '0;
                        n_out_cy    = '0;
                        n_out_last  = !send_summary;
                    end

                    if (send_summary) begin
                        n_none  = small_win || (upd_white == '0);
                        n_dvd   = DVD_W'(upd_sum_x) << FRACTION_BITS;
                        n_rem   = '0;
                        n_step  = '0;
                        n_div_y = 1'b0;
                        n_state = (small_win || (upd_white == '0)) ? S_SUM : S_DIV;
                    end
                end
            end

            S_DIV: begin
                n_dvd = quotient;
                n_rem = COUNT_W'(rem_ge ? rem_shift - {1'b0, r_white} : rem_shift);
                if (r_step == STEP_LAST) begin
                    n_step = '0;
                    if (!r_div_y) begin
                        // x is done; restart the divider on the y sum.
                        n_cent_x = quot_sat;
                        n_dvd    = DVD_W'(r_sum_y) << FRACTION_BITS;
                        n_rem    = '0;
                        n_div_y  = 1'b1;
                    end else begin
                        n_cent_y = quot_sat;
                        n_state  = S_SUM;
                    end
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end

            S_SUM: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_SUMMARY;
                    n_out_pixel = PIXEL_BLACK;
                    n_out_count = r_none ? '0 : r_white;
                    n_out_cx    = r_none ? CENT_NONE : r_cent_x;
                    n_out_cy    = r_none ? CENT_NONE : r_cent_y;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_white     <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_sum_x     <= n_sum_x;
            if (r_state == S_IDLE && in_accept) begin
                r_sum_y <= n_sum_y;
            end
            r_white     <= n_white;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
        r_none      <= n_none;
        r_dvd       <= n_dvd;
        r_rem       <= n_rem;
        r_step      <= n_step;
        r_div_y     <= n_div_y;
        r_cent_x    <= n_cent_x;
        r_cent_y    <= n_cent_y;
        r_out_kind  <= n_out_kind;
        r_out_pixel <= n_out_pixel;
        r_out_count <= n_out_count;
        r_out_cx    <= n_out_cx;
        r_out_cy    <= n_out_cy;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_out_kind;
    assign o_binary_pixel = r_out_pixel;
    assign o_white_count  = r_out_count;
    assign o_centroid_x   = $signed(r_out_cx);
    assign o_centroid_y   = $signed(r_out_cy);
    assign o_last         = r_out_last;

`ifndef NO_ASSERTIONS
    // The divider only runs with a nonzero white count as divisor.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_white != '0))
        else $error("divider running with zero divisor");

    // While a summary is being built, this frame's summary is already marked sent.
    a_done_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV || r_state == S_SUM) |-> r_done)
        else $error("summary pending without window_done set");

    // A summary word is always the final word of its input word.
    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == KIND_SUMMARY) |-> o_last)
        else $error("summary word without last");

    // Leaving the summary state always loads a summary word into the result register.
    a_summary_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM && slot_free) |=>
            (o_out_valid && o_result_kind == KIND_SUMMARY && r_state == S_IDLE))
        else $error("summary state left without a summary word");
`endif

endmodule

>>> dv/testbench.sv
// Self-checking testbench for window_binarize_centroid_unit: crop window binarizing,
// white pixel moments and the centroid word, checked against an in-bench predictor.
// Depends on wbc_pkg and the RTL of the unit; needs no other file.
`timescale 1ns / 1ps

module testbench;
    import wbc_pkg::*;

    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 1024;
    localparam int FRAC          = 8;
    // Two divisions plus slack; covers a closing word still at work.
    localparam int SETTLE_CYCLES = 2 * (32 + FRAC) + 60;
    localparam int LIMIT_CYCLES  = 5_000_000;
    localparam int RANDOM_WORDS  = 500;

    localparam logic [CENT_W-1:0] NO_CENTROID = CENT_W'(-(1 << FRAC));

    typedef struct packed {
        logic [15:0] pixel;
        logic        start;
    } pixel_in_t;

    typedef struct packed {
        logic               kind;
        logic [15:0]        pixel;
        logic [COUNT_W-1:0] count;
        logic [CENT_W-1:0]  cx;
        logic [CENT_W-1:0]  cy;
        logic               last;
    } window_result_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [15:0]              i_pixel_word = '0;
    logic                     i_frame_start = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic                     o_result_kind;
    logic [15:0]              o_binary_pixel;
    logic [COUNT_W-1:0]       o_white_count;
    logic signed [CENT_W-1:0] o_centroid_x;
    logic signed [CENT_W-1:0] o_centroid_y;
    logic                     o_last;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;

    window_binarize_centroid_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_pixel_word   (i_pixel_word),
        .i_frame_start  (i_frame_start),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_kind  (o_result_kind),
        .o_binary_pixel (o_binary_pixel),
        .o_white_count  (o_white_count),
        .o_centroid_x   (o_centroid_x),
        .o_centroid_y   (o_centroid_y),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Register image and frame state of the predictor.
    logic [7:0]         cfg_threshold;
    logic [9:0]         cfg_left;
    logic [9:0]         cfg_top;
    logic [10:0]        cfg_width;
    logic [10:0]        cfg_height;
    logic [10:0]        cfg_frame_width;
    logic               cfg_emit;
    int unsigned        col_pos;
    int unsigned        row_pos;
    logic [31:0]        sum_x;
    logic [31:0]        sum_y;
    logic [COUNT_W-1:0] white_total;
    logic               window_done;

    pixel_in_t      pixel_backlog[$];
    window_result_t predicted_outputs[$];

    logic        word_taken = 1'b0;
    logic        reg_taken = 1'b0;
    logic        quiet_in = 1'b0;
    logic        quiet_out = 1'b0;
    int          in_gap = 0;
    int          stall_left = 0;
    int          errors = 0;
    int          cycle_count = 0;
    int unsigned words_queued = 0;
    bit          settled = 1'b1;

    // Effective frame width and the clipped right and bottom window edges.
    task automatic window_bounds(output int unsigned fw, output int unsigned right,
                                 output int unsigned bottom);
        fw = cfg_frame_width;
        if (fw == 0 || fw > MAX_W)
            fw = MAX_W;
        right = cfg_left + {cfg_width[10:3], 3'b000};
        if (right > fw)
            right = fw;
        bottom = cfg_top + cfg_height;
        if (bottom > MAX_H)
            bottom = MAX_H;
    endtask

    // Truncated Q.8 mean of a coordinate sum, saturated at the field maximum.
    function automatic logic [CENT_W-1:0] mean_q8(logic [31:0] sum);
        logic [63:0] q;
        q = ({32'd0, sum} << FRAC) / {43'd0, white_total};
        if (q > 64'(CENT_MAX))
            q = 64'(CENT_MAX);
        return q[CENT_W-1:0];
    endfunction

    function automatic window_result_t summary_word(int unsigned area);
        window_result_t r;
        r      = '0;
        r.kind = KIND_SUMMARY;
        if (area < 8 || white_total == 0) begin
            r.cx = NO_CENTROID;
            r.cy = NO_CENTROID;
        end else begin
            r.count = white_total;
            r.cx    = mean_q8(sum_x);
            r.cy    = mean_q8(sum_y);
        end
        return r;
    endfunction

    // Advances the frame position by one word and queues the words it should produce.
    task automatic binarize_and_accumulate(pixel_in_t w);
        int unsigned    fw, right, bottom, area;
        logic           empty, white;
        window_result_t r;
        window_result_t made[$];
        if (w.start) begin
            col_pos     = 0;
            row_pos     = 0;
            sum_x       = '0;
            sum_y       = '0;
            white_total = '0;
            window_done = 1'b0;
        end
        window_bounds(fw, right, bottom);
        empty = (right <= cfg_left) || (bottom <= cfg_top);
        area  = empty ? 0 : (right - cfg_left) * (bottom - cfg_top);
        if (!window_done) begin
            if (empty) begin
                made.push_back(summary_word(0));
                window_done = 1'b1;
            end else if (col_pos >= cfg_left && col_pos < right &&
                         row_pos >= cfg_top && row_pos < bottom) begin
                white = w.pixel[7:0] >= cfg_threshold;
                if (white) begin
                    white_total = white_total + 1'b1;
                    sum_x       = sum_x + 32'(col_pos - cfg_left);
                    sum_y       = sum_y + 32'(row_pos - cfg_top);
                end
                if (cfg_emit) begin
                    r       = '0;
                    r.kind  = KIND_BINARY;
                    r.pixel = white ? PIXEL_WHITE : PIXEL_BLACK;
                    made.push_back(r);
                end
                if (col_pos == right - 1 && row_pos == bottom - 1) begin
                    made.push_back(summary_word(area));
                    window_done = 1'b1;
                end
            end
        end
        col_pos++;
        if (col_pos >= fw) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= MAX_H)
                row_pos = 0;
        end
        foreach (made[i]) begin
            r      = made[i];
            r.last = (i == made.size() - 1);
            predicted_outputs.push_back(r);
        end
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    // Captures register writes, predicts accepted pixel words and checks result words.
    always @(posedge i_clk) begin : monitor
        window_result_t want;
        if (!i_rst_n) begin
            cfg_threshold   = RST_THRESHOLD;
            cfg_left        = RST_WINDOW_LEFT;
            cfg_top         = RST_WINDOW_TOP;
            cfg_width       = RST_WINDOW_WIDTH;
            cfg_height      = RST_WINDOW_HEIGHT;
            cfg_frame_width = RST_FRAME_WIDTH;
            cfg_emit        = RST_EMIT_BINARY;
            col_pos         = 0;
            row_pos         = 0;
            sum_x           = '0;
            sum_y           = '0;
            white_total     = '0;
            window_done     = 1'b0;
            word_taken <= 1'b0;
            reg_taken  <= 1'b0;
        end else begin
            word_taken <= i_in_valid && !o_in_stall;
            reg_taken  <= i_cfg_valid && o_cfg_ready;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_THRESHOLD:     cfg_threshold   = i_cfg_data[7:0];
                    CFG_WINDOW_LEFT:   cfg_left        = i_cfg_data[9:0];
                    CFG_WINDOW_TOP:    cfg_top         = i_cfg_data[9:0];
                    CFG_WINDOW_WIDTH:  cfg_width       = i_cfg_data;
                    CFG_WINDOW_HEIGHT: cfg_height      = i_cfg_data;
                    CFG_FRAME_WIDTH:   cfg_frame_width = i_cfg_data;
                    CFG_EMIT_BINARY:   cfg_emit        = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall)
                binarize_and_accumulate('{pixel: i_pixel_word, start: i_frame_start});
            if (o_out_valid && !i_out_stall) begin
                if (predicted_outputs.size() == 0) begin
                    $error("result word with nothing expected, kind %0d", o_result_kind);
                    errors++;
                end else begin
                    want = predicted_outputs.pop_front();
                    check_field("result_kind", want.kind, o_result_kind);
                    check_field("binary_pixel", want.pixel, o_binary_pixel);
                    check_field("white_count", want.count, o_white_count);
                    check_field("centroid_x", want.cx, {13'd0, o_centroid_x});
                    check_field("centroid_y", want.cy, {13'd0, o_centroid_y});
                    check_field("last", want.last, o_last);
                end
            end
        end
    end

    // Mostly short gaps, a few long ones.
    function automatic int idle_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(1, 2);
        if (pick < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // Each side switches now and then between idling at random and running flat out.
    always @(negedge i_clk) begin
        if ($urandom_range(0, 299) == 0)
            quiet_in <= !quiet_in;
        if ($urandom_range(0, 299) == 0)
            quiet_out <= !quiet_out;
    end

    // Sender: holds a word until it is taken, then leaves a random gap.
    always @(negedge i_clk) begin : driver
        pixel_in_t w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || word_taken) begin
            if (in_gap > 0) begin
                in_gap     <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pixel_backlog.size() > 0) begin
                w = pixel_backlog.pop_front();
                i_in_valid    <= 1'b1;
                i_pixel_word  <= w.pixel;
                i_frame_start <= w.start;
                in_gap        <= (quiet_in || $urandom_range(0, 2) != 0) ? 0 : idle_len();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls in bursts of random length.
    always @(negedge i_clk) begin : stall_gen
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (!quiet_out && $urandom_range(0, 3) == 0) begin
            stall_left  <= idle_len() - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Returns once every word has been sent, every result has come and the unit has settled.
    task automatic wait_idle();
        while (pixel_backlog.size() != 0 || i_in_valid)
            @(negedge i_clk);
        while (predicted_outputs.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        settled = 1'b1;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, int unsigned value);
        if (!settled)
            wait_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= CFG_DATA_W'(value);
        do @(negedge i_clk); while (!reg_taken);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_window(int unsigned left, int unsigned top, int unsigned width,
                              int unsigned height, int unsigned fw);
        write_reg(CFG_WINDOW_LEFT, left);
        write_reg(CFG_WINDOW_TOP, top);
        write_reg(CFG_WINDOW_WIDTH, width);
        write_reg(CFG_WINDOW_HEIGHT, height);
        write_reg(CFG_FRAME_WIDTH, fw);
    endtask

    // Queues pixel words with luma in [lo, hi] and random chroma; the first may start a frame.
    task automatic queue_words(int unsigned n, bit start, int unsigned lo, int unsigned hi);
        pixel_in_t w;
        for (int unsigned i = 0; i < n; i++) begin
            w.pixel       = 16'($urandom_range(0, 65535));
            w.pixel[7:0]  = 8'($urandom_range(lo, hi));
            w.start       = start && (i == 0);
            pixel_backlog.push_back(w);
        end
        words_queued += n;
        settled = 1'b0;
    endtask

    task automatic random_settings();
        int unsigned fw, left;
        fw   = $urandom_range(1, 16);
        left = ($urandom_range(0, 9) == 0) ? $urandom_range(fw, 1023)
                                           : $urandom_range(0, fw - 1);
        set_window(left, $urandom_range(0, 3), $urandom_range(0, 31),
                   ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4), fw);
        case ($urandom_range(0, 9))
            0:       write_reg(CFG_THRESHOLD, 0);
            1:       write_reg(CFG_THRESHOLD, 255);
            default: write_reg(CFG_THRESHOLD, $urandom_range(0, 255));
        endcase
        write_reg(CFG_EMIT_BINARY, $urandom_range(0, 1));
    endtask

    // One frame through its closing pixel and a few spare words; now and then cut short.
    task automatic queue_random_frame();
        int unsigned fw, right, bottom, span, lo, hi;
        window_bounds(fw, right, bottom);
        if (right <= cfg_left || bottom <= cfg_top) begin
            span = $urandom_range(1, 3);
        end else begin
            span = (bottom - 1) * fw + right;
            if ($urandom_range(0, 7) == 0)
                span = $urandom_range(1, span);
            else
                span += $urandom_range(0, 3);
        end
        lo = 0;
        hi = 255;
        if ($urandom_range(0, 1) == 0) begin
            lo = (cfg_threshold > 2) ? cfg_threshold - 2 : 0;
            hi = (cfg_threshold < 255) ? cfg_threshold + 1 : 255;
        end
        queue_words(span, 1'b1, lo, hi);
        // Stray words after the frame, which the unit drops unless the frame was cut short.
        if ($urandom_range(0, 5) == 0)
            queue_words($urandom_range(1, 4), 1'b0, 0, 255);
    endtask

    initial begin : stimulus
        int unsigned directed_words;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Lowest threshold makes every pixel white; highest leaves only luma 255.
        set_window(0, 0, 8, 2, 8);
        write_reg(CFG_EMIT_BINARY, 1);
        write_reg(CFG_THRESHOLD, 0);
        queue_words(16, 1'b1, 0, 255);
        write_reg(CFG_THRESHOLD, 255);
        queue_words(16, 1'b1, 250, 255);
        queue_words(18, 1'b1, 0, 254);

        // A three-pixel frame clips the window to six pixels, too few for a centroid.
        set_window(0, 0, 8, 2, 3);
        write_reg(CFG_THRESHOLD, 100);
        queue_words(8, 1'b1, 0, 255);

        // Centroid only, with odd window width bits dropped.
        set_window(2, 1, 13, 3, 12);
        write_reg(CFG_EMIT_BINARY, 0);
        queue_words(48, 1'b1, 0, 255);

        // Window running past the right frame edge.
        set_window(6, 1, 1024, 2, 10);
        write_reg(CFG_EMIT_BINARY, 1);
        queue_words(32, 1'b1, 90, 110);

        // Empty windows: zero height, then a left edge at the frame's right edge.
        set_window(1023, 1023, 1024, 0, 2047);
        queue_words(3, 1'b1, 0, 255);
        queue_words(2, 1'b1, 0, 255);
        set_window(8, 0, 8, 1024, 8);
        queue_words(2, 1'b1, 0, 255);

        // A frame width of zero acts as the widest frame, so columns 8 to 15 exist.
        set_window(8, 0, 8, 1, 0);
        write_reg(CFG_THRESHOLD, 128);
        queue_words(18, 1'b1, 0, 255);

        // The window is moved mid-frame to a row passed already: no summary this frame.
        set_window(0, 6, 8, 1, 1);
        queue_words(5, 1'b1, 0, 255);
        write_reg(CFG_WINDOW_TOP, 2);
        queue_words(6, 1'b0, 0, 255);

        // Shrinking the window mid-frame past its end point: no summary this frame.
        set_window(0, 0, 8, 4, 8);
        write_reg(CFG_EMIT_BINARY, 0);
        queue_words(20, 1'b1, 0, 255);
        write_reg(CFG_WINDOW_HEIGHT, 2);
        queue_words(20, 1'b0, 0, 255);

        directed_words = words_queued;
        while (words_queued < directed_words + RANDOM_WORDS) begin
            random_settings();
            repeat ($urandom_range(1, 4))
                queue_random_frame();
        end

        wait_idle();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
